// ===== design/hcs_pkg.sv =====
// Shared types and constants for the hashed cell set.
`timescale 1ns / 1ps
`default_nettype none

package hcs_pkg;

    localparam int FUNC_W  = 3;
    localparam int COORD_W = 16;
    localparam int STAT_W  = 2;
    localparam int POP_W   = 7;

    localparam int unsigned HASH_MUL    = 31;
    localparam int unsigned HASH_MUL_SQ = 961;

    localparam logic [FUNC_W-1:0] FN_CONTAINS = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ADD      = 3'd1;
    localparam logic [FUNC_W-1:0] FN_REMOVE   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_CLEAR    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_BOUNDS   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [COORD_W-1:0] cell_x;
        logic signed [COORD_W-1:0] cell_y;
        logic signed [COORD_W-1:0] cell_z;
    } t_in;

    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic                      hit;
        logic [POP_W-1:0]          population;
        logic signed [COORD_W-1:0] box_low_x;
        logic signed [COORD_W-1:0] box_low_y;
        logic signed [COORD_W-1:0] box_low_z;
        logic signed [COORD_W-1:0] box_high_x;
        logic signed [COORD_W-1:0] box_high_y;
        logic signed [COORD_W-1:0] box_high_z;
    } t_out;

    typedef struct packed {
        logic start;
        logic look;
        logic clr_wr;
        logic bnd_rd;
        logic bnd_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic addr_last;
        logic way_last;
        logic count_zero;
    } t_stat;

endpackage

`default_nettype wire

// ===== design/hcs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module hcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/hcs_ctrl.sv =====
// Controller state machine for the hashed cell set.
`timescale 1ns / 1ps
`default_nettype none

module hcs_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic [hcs_pkg::FUNC_W-1:0] i_func,
    output logic                            o_in_stall,
    output hcs_pkg::t_cmd                   o_cmd,
    input  wire hcs_pkg::t_stat             i_stat
);

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_LOOK  = 7'b0000100,
        S_CLR   = 7'b0001000,
        S_BRD   = 7'b0010000,
        S_BWALK = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.addr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    if (i_func inside {hcs_pkg::FN_CONTAINS, hcs_pkg::FN_ADD,
                                       hcs_pkg::FN_REMOVE}) begin
                        n_state = S_LOOK;
                    end else if (i_func == hcs_pkg::FN_CLEAR) begin
                        n_state = S_CLR;
                    end else if (i_func == hcs_pkg::FN_BOUNDS && !i_stat.count_zero) begin
                        n_state = S_BRD;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.addr_last) begin
                    n_state = S_FIN;
                end
            end
            S_BRD: begin
                o_cmd.bnd_rd = 1'b1;
                n_state      = S_BWALK;
            end
            S_BWALK: begin
                o_cmd.bnd_step = 1'b1;
                if (i_stat.way_last) begin
                    n_state = i_stat.addr_last ? S_FIN : S_BRD;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/hcs_dp.sv =====
// Datapath of the hashed cell set: bucket RAM, match logic, box scan and result register.
`timescale 1ns / 1ps
`default_nettype none

module hcs_dp #(
    parameter int BUCKETS    = 16,
    parameter int WAYS       = 4,
    parameter int COORD_BITS = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire hcs_pkg::t_in   i_in_data,
    input  wire hcs_pkg::t_cmd  i_cmd,
    output hcs_pkg::t_stat      o_stat,
    output logic                o_out_valid,
    output hcs_pkg::t_out       o_out_data,
    input  wire logic           i_out_stall
);

    localparam int CB    = COORD_BITS;
    localparam int EW    = 1 + 3 * CB;
    localparam int RW    = WAYS * EW;
    localparam int HB    = $clog2(BUCKETS);
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SLOTS = BUCKETS * WAYS;
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int IW    = hcs_pkg::COORD_W;
    localparam int PW    = hcs_pkg::POP_W;
    localparam int FW    = hcs_pkg::FUNC_W;
    localparam int SW    = hcs_pkg::STAT_W;

    logic [CB-1:0] in_x, in_y, in_z;
    logic [HB-1:0] hx, hy, hz, in_hash;

    logic [FW-1:0] r_func;
    logic [CB-1:0] r_x, r_y, r_z;
    logic [HB-1:0] r_bucket;
    logic [HB-1:0] r_addr;
    logic [WW-1:0] r_way;
    logic          r_first;
    logic [SW-1:0] r_status, n_status;
    logic          r_hit, n_hit;
    logic [CW-1:0] r_count, n_count;
    logic [CB-1:0] r_lo [3];
    logic [CB-1:0] r_hi [3];
    logic          r_out_valid;
    hcs_pkg::t_out r_out;

    logic          ram_re, ram_we;
    logic [HB-1:0] ram_raddr, ram_waddr;
    logic [RW-1:0] ram_wdata, ram_rdata, look_row;

    logic [WAYS-1:0] match, free;
    logic            found, has_free, ins, del;
    logic [WW-1:0]   mi, fi;
    logic [EW-1:0]   ent, cur;
    logic [CB-1:0]   cur_c [3];
    logic            way_last, addr_last, out_free;

    // A field wider than the stored coordinate is cut, a narrower one is zero-extended.
    assign in_x = CB'($unsigned(i_in_data.cell_x));
    assign in_y = CB'($unsigned(i_in_data.cell_y));
    assign in_z = CB'($unsigned(i_in_data.cell_z));

    assign hx      = HB'($signed(in_x));
    assign hy      = HB'($signed(in_y));
    assign hz      = HB'($signed(in_z));
    assign in_hash = hx * HB'(hcs_pkg::HASH_MUL_SQ) + hy * HB'(hcs_pkg::HASH_MUL) + hz;

    hcs_ram #(
        .WIDTH (RW),
        .DEPTH (BUCKETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        match    = '0;
        free     = '0;
        mi       = '0;
        fi       = '0;
        ent      = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            ent      = ram_rdata[w*EW +: EW];
            match[w] = ent[EW-1] && (ent[EW-2:0] == {r_x, r_y, r_z});
            free[w]  = !ent[EW-1];
            if (match[w]) begin
                mi = WW'(w);
            end
            if (free[w]) begin
                fi = WW'(w);
            end
        end
        found    = |match;
        has_free = |free;
        ins      = (r_func == hcs_pkg::FN_ADD) && !found && has_free;
        del      = (r_func == hcs_pkg::FN_REMOVE) && found;
        look_row = ram_rdata;
        if (ins) begin
            look_row[int'(fi)*EW +: EW] = {1'b1, r_x, r_y, r_z};
        end
        if (del) begin
            look_row[int'(mi)*EW + EW - 1] = 1'b0;
        end
    end

    assign ram_re    = i_cmd.start | i_cmd.bnd_rd;
    assign ram_raddr = i_cmd.start ? in_hash : r_addr;
    assign ram_we    = i_cmd.clr_wr | (i_cmd.look & (ins | del));
    assign ram_waddr = i_cmd.clr_wr ? r_addr : r_bucket;
    assign ram_wdata = i_cmd.clr_wr ? '0 : look_row;

    always_comb begin
        n_status = r_status;
        n_hit    = r_hit;
        n_count  = r_count;
        if (i_cmd.start) begin
            n_hit    = 1'b0;
            n_status = (i_in_data.func == hcs_pkg::FN_BOUNDS && r_count == '0)
                       ? hcs_pkg::ST_EMPTY : hcs_pkg::ST_OK;
            if (i_in_data.func == hcs_pkg::FN_CLEAR) begin
                n_count = '0;
            end
        end
        if (i_cmd.look) begin
            case (r_func)
                hcs_pkg::FN_CONTAINS: begin
                    n_hit = found;
                end
                hcs_pkg::FN_ADD: begin
                    if (!found) begin
                        if (has_free) begin
                            n_hit   = 1'b1;
                            n_count = CW'(r_count + 1'b1);
                        end else begin
                            n_status = hcs_pkg::ST_FULL;
                        end
                    end
                end
                hcs_pkg::FN_REMOVE: begin
                    if (found) begin
                        n_hit   = 1'b1;
                        n_count = CW'(r_count - 1'b1);
                    end
                end
                default: begin
                    n_hit = r_hit;
                end
            endcase
        end
    end

    assign cur      = ram_rdata[int'(r_way)*EW +: EW];
    assign cur_c[0] = cur[3*CB-1:2*CB];
    assign cur_c[1] = cur[2*CB-1:CB];
    assign cur_c[2] = cur[CB-1:0];

    assign way_last  = (r_way == WW'(WAYS - 1));
    assign addr_last = (r_addr == HB'(BUCKETS - 1));
    assign out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_way       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.clr_wr || (i_cmd.bnd_step && way_last)) begin
                r_addr <= r_addr + 1'b1;
            end
            if (i_cmd.start || (i_cmd.bnd_step && way_last)) begin
                r_way <= '0;
            end else if (i_cmd.bnd_step) begin
                r_way <= r_way + 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_hit    <= n_hit;
        if (i_cmd.start) begin
            r_func   <= i_in_data.func;
            r_x      <= in_x;
            r_y      <= in_y;
            r_z      <= in_z;
            r_bucket <= in_hash;
            r_first  <= 1'b1;
            for (int a = 0; a < 3; a++) begin
                r_lo[a] <= '0;
                r_hi[a] <= '0;
            end
        end else if (i_cmd.bnd_step && cur[EW-1]) begin
            r_first <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                if (r_first || $signed(cur_c[a]) < $signed(r_lo[a])) begin
                    r_lo[a] <= cur_c[a];
                end
                if (r_first || $signed(cur_c[a]) > $signed(r_hi[a])) begin
                    r_hi[a] <= cur_c[a];
                end
            end
        end
        if (i_cmd.load_out) begin
            r_out.status     <= n_status;
            r_out.hit        <= n_hit;
            r_out.population <= PW'(n_count);
            r_out.box_low_x  <= IW'($signed(r_lo[0]));
            r_out.box_low_y  <= IW'($signed(r_lo[1]));
            r_out.box_low_z  <= IW'($signed(r_lo[2]));
            r_out.box_high_x <= IW'($signed(r_hi[0]));
            r_out.box_high_y <= IW'($signed(r_hi[1]));
            r_out.box_high_z <= IW'($signed(r_hi[2]));
        end
    end

    assign o_stat.out_free   = out_free;
    assign o_stat.addr_last  = addr_last;
    assign o_stat.way_last   = way_last;
    assign o_stat.count_zero = (r_count == '0);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== design/hashed_cell_set_with_bounds_top.sv =====
// Top level of the hashed cell set with bounding-box query.
//
// An item on the input channel carries an operation code and a signed 3D cell.
// Every item yields exactly one result item on the output channel. Both channels
// use valid and stall; an item moves when valid is high and stall is low.
// The set lives in a RAM of BUCKETS rows, each row holding the WAYS entries of one
// bucket, so a lookup costs one row read and at most one row write.
// Contains, add and remove read the bucket row when the item is accepted, then
// update the row and register the result once the output register is free.
// Clear writes every row.
// Bounds reads every row and checks one way per cycle; on an empty set it skips
// the scan and reports the empty status.
// After reset the block clears the RAM one row per cycle and holds the input
// stall high meanwhile.
// A result waits in the output register while the receiver stalls; the block
// still accepts the next item and holds its result until the register frees up.
`timescale 1ns / 1ps
`default_nettype none

module hashed_cell_set_with_bounds_top #(
    parameter int BUCKETS    = 16,
    parameter int WAYS       = 4,
    parameter int COORD_BITS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire hcs_pkg::t_in  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output hcs_pkg::t_out      o_out_data,
    input  wire logic          i_out_stall
);

    hcs_pkg::t_cmd  cmd;
    hcs_pkg::t_stat stat;

    hcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in_data.func),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    hcs_dp #(
        .BUCKETS    (BUCKETS),
        .WAYS       (WAYS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the hashed cell set: a tracking scoreboard, stimulus tasks and the top.
`timescale 1ns / 1ps

module tb_top;
    import hcs_pkg::*;

    localparam int NUM_BUCKETS = 16;
    localparam int NUM_WAYS    = 4;
    localparam int NUM_SLOTS   = NUM_BUCKETS * NUM_WAYS;
    localparam int ITEM_TARGET = 1850;
    localparam int LIMIT_CYCLES = 800000;
    localparam int DRAIN_CYCLES = 120;
    localparam int CALM_FIRST  = 700;
    localparam int CALM_LAST   = 1000;

    localparam logic [FUNC_W-1:0] FN_SPARE_LO  = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SPARE_MID = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_HI  = 3'd7;

    localparam logic signed [COORD_W-1:0] C_MIN = 16'sh8000;
    localparam logic signed [COORD_W-1:0] C_MAX = 16'sh7FFF;

    typedef logic signed [COORD_W-1:0] coord_t;

    class cell_set_tracker;
        typedef struct {
            bit     used;
            coord_t x;
            coord_t y;
            coord_t z;
        } slot_t;

        slot_t       slots[NUM_SLOTS];
        int unsigned stored;
        t_out        pending[$];
        int          mismatches;
        int          checked;
        int          refusals;
        int          empty_bounds;
        int          peak;

        function new();
            foreach (slots[i]) slots[i].used = 1'b0;
            stored = 0;
        endfunction

        static function int unsigned bucket_for(coord_t x, coord_t y, coord_t z);
            longint unsigned h;
            h = longint'(x) * HASH_MUL_SQ + longint'(y) * HASH_MUL + longint'(z);
            return int'(h % NUM_BUCKETS);
        endfunction

        function int find_way(int base, coord_t x, coord_t y, coord_t z);
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (slots[base + w].used && slots[base + w].x == x &&
                    slots[base + w].y == y && slots[base + w].z == z) return w;
            end
            return -1;
        endfunction

        function t_out apply_op(t_in op);
            t_out r;
            int   base;
            int   way;
            bit   any;
            r = '0;
            base = bucket_for(op.cell_x, op.cell_y, op.cell_z) * NUM_WAYS;
            way = find_way(base, op.cell_x, op.cell_y, op.cell_z);
            any = 1'b0;
            case (op.func)
                FN_CONTAINS: begin
                    r.hit = (way >= 0);
                end
                FN_ADD: begin
                    if (way < 0) begin
                        for (way = 0; way < NUM_WAYS; way++)
                            if (!slots[base + way].used) break;
                        if (way == NUM_WAYS) begin
                            r.status = ST_FULL;
                            refusals++;
                        end else begin
                            slots[base + way].used = 1'b1;
                            slots[base + way].x = op.cell_x;
                            slots[base + way].y = op.cell_y;
                            slots[base + way].z = op.cell_z;
                            stored++;
                            r.hit = 1'b1;
                        end
                    end
                end
                FN_REMOVE: begin
                    if (way >= 0) begin
                        slots[base + way].used = 1'b0;
                        if (stored > 0) stored--;
                        r.hit = 1'b1;
                    end
                end
                FN_CLEAR: begin
                    foreach (slots[i]) slots[i].used = 1'b0;
                    stored = 0;
                end
                FN_BOUNDS: begin
                    foreach (slots[i]) begin
                        if (!slots[i].used) continue;
                        if (!any) begin
                            r.box_low_x = slots[i].x;
                            r.box_low_y = slots[i].y;
                            r.box_low_z = slots[i].z;
                            r.box_high_x = slots[i].x;
                            r.box_high_y = slots[i].y;
                            r.box_high_z = slots[i].z;
                            any = 1'b1;
                        end else begin
                            if (slots[i].x < r.box_low_x) r.box_low_x = slots[i].x;
                            if (slots[i].y < r.box_low_y) r.box_low_y = slots[i].y;
                            if (slots[i].z < r.box_low_z) r.box_low_z = slots[i].z;
                            if (slots[i].x > r.box_high_x) r.box_high_x = slots[i].x;
                            if (slots[i].y > r.box_high_y) r.box_high_y = slots[i].y;
                            if (slots[i].z > r.box_high_z) r.box_high_z = slots[i].z;
                        end
                    end
                    if (!any) begin
                        r.status = ST_EMPTY;
                        empty_bounds++;
                    end
                end
                default: begin
                end
            endcase
            r.population = stored[POP_W-1:0];
            if (int'(stored) > peak) peak = stored;
            return r;
        endfunction

        function void note_op(t_in op);
            pending.push_back(apply_op(op));
        endfunction

        function string describe(t_out r);
            return $sformatf("status=%0d hit=%0d pop=%0d low=(%0d,%0d,%0d) high=(%0d,%0d,%0d)",
                             r.status, r.hit, r.population, r.box_low_x, r.box_low_y,
                             r.box_low_z, r.box_high_x, r.box_high_y, r.box_high_z);
        endfunction

        function void check_result(t_out got);
            t_out  want;
            string bad;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result item: %s", describe(got));
                return;
            end
            want = pending.pop_front();
            bad = "";
            if (got.status !== want.status) bad = {bad, " status"};
            if (got.hit !== want.hit) bad = {bad, " hit"};
            if (got.population !== want.population) bad = {bad, " population"};
            if (got.box_low_x !== want.box_low_x) bad = {bad, " box_low_x"};
            if (got.box_low_y !== want.box_low_y) bad = {bad, " box_low_y"};
            if (got.box_low_z !== want.box_low_z) bad = {bad, " box_low_z"};
            if (got.box_high_x !== want.box_high_x) bad = {bad, " box_high_x"};
            if (got.box_high_y !== want.box_high_y) bad = {bad, " box_high_y"};
            if (got.box_high_z !== want.box_high_z) bad = {bad, " box_high_z"};
            if (bad != "") begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Mismatch on result %0d in%s", checked, bad);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    t_in  i_in_data = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    cell_set_tracker tracker = new();
    int sent = 0;
    bit calm = 1'b0;

    hashed_cell_set_with_bounds_top #(
        .BUCKETS(NUM_BUCKETS),
        .WAYS(NUM_WAYS),
        .COORD_BITS(COORD_W)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in_data(i_in_data),
        .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_data(o_out_data),
        .i_out_stall(i_out_stall)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < 16);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) tracker.check_result(o_out_data);
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("Timeout with %0d results still pending.", tracker.pending.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic coord_t rand_coord();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return C_MIN;
        if (pick == 1) return C_MAX;
        if (pick <= 3) return coord_t'($urandom_range(0, 8)) - coord_t'(4);
        return coord_t'($urandom);
    endfunction

    function automatic t_in make_op(logic [FUNC_W-1:0] f, coord_t x, coord_t y, coord_t z);
        t_in op;
        op.func = f;
        op.cell_x = x;
        op.cell_y = y;
        op.cell_z = z;
        return op;
    endfunction

    function automatic t_in cell_in_bucket(int unsigned b);
        coord_t      x;
        coord_t      y;
        coord_t      z;
        int unsigned h0;
        x = rand_coord();
        y = rand_coord();
        h0 = cell_set_tracker::bucket_for(x, y, coord_t'(0));
        z = coord_t'($urandom) & ~coord_t'(NUM_BUCKETS - 1);
        z = z | coord_t'((b - h0) & (NUM_BUCKETS - 1));
        return make_op(FN_ADD, x, y, z);
    endfunction

    task automatic send_op(input t_in op);
        calm = (sent >= CALM_FIRST) && (sent < CALM_LAST);
        while (!calm && $urandom_range(0, 99) < 16) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= op;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_op(op);
        sent++;
    endtask

    task automatic send_as(input logic [FUNC_W-1:0] f, input t_in src);
        send_op(make_op(f, src.cell_x, src.cell_y, src.cell_z));
    endtask

    task automatic run_directed();
        send_op(make_op(FN_BOUNDS, 0, 0, 0));
        send_op(make_op(FN_CONTAINS, 0, 0, 0));
        send_op(make_op(FN_REMOVE, 0, 0, 0));
        send_op(make_op(FN_ADD, C_MIN, C_MIN, C_MIN));
        send_op(make_op(FN_ADD, C_MAX, C_MAX, C_MAX));
        send_op(make_op(FN_ADD, C_MAX, C_MAX, C_MAX));
        send_op(make_op(FN_CONTAINS, C_MAX, C_MAX, C_MAX));
        send_op(make_op(FN_BOUNDS, 0, 0, 0));
        // The minimum cell already sits in bucket 0, so three more fill it.
        send_op(make_op(FN_ADD, 0, 0, 0));
        send_op(make_op(FN_ADD, 0, 0, 16));
        send_op(make_op(FN_ADD, 0, 0, 32));
        send_op(make_op(FN_ADD, 0, 0, 48));
        send_op(make_op(FN_REMOVE, 0, 0, 16));
        send_op(make_op(FN_ADD, 0, 0, 48));
        send_op(make_op(FN_CONTAINS, 0, 0, 16));
        send_op(make_op(FN_SPARE_LO, C_MAX, C_MIN, -1));
        send_op(make_op(FN_SPARE_MID, C_MIN, C_MAX, 1));
        send_op(make_op(FN_SPARE_HI, -1, -1, -1));
        send_op(make_op(FN_BOUNDS, 0, 0, 0));
        send_op(make_op(FN_REMOVE, C_MIN, C_MIN, C_MIN));
        send_op(make_op(FN_BOUNDS, 0, 0, 0));
        send_op(make_op(FN_CLEAR, 0, 0, 0));
        send_op(make_op(FN_BOUNDS, 0, 0, 0));
        send_op(make_op(FN_CONTAINS, 0, 0, 0));
        send_op(make_op(FN_ADD, -1, 0, 1));
    endtask

    // Fills every bucket past its capacity, then works the full set with mixed operations.
    task automatic run_packing();
        t_in cells[$];
        t_in tmp;
        int  j;
        send_op(make_op(FN_CLEAR, 0, 0, 0));
        for (int b = 0; b < NUM_BUCKETS; b++)
            for (int k = 0; k <= NUM_WAYS; k++) cells.push_back(cell_in_bucket(b));
        for (int i = cells.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = cells[i];
            cells[i] = cells[j];
            cells[j] = tmp;
        end
        foreach (cells[i]) send_as(FN_ADD, cells[i]);
        send_op(make_op(FN_BOUNDS, 0, 0, 0));
        for (int i = 0; i < 20; i++) begin
            j = $urandom_range(0, cells.size() - 1);
            case ($urandom_range(0, 3))
                0: send_as(FN_CONTAINS, cells[j]);
                1: send_as(FN_REMOVE, cells[j]);
                2: send_as(FN_ADD, cells[j]);
                default: send_op(make_op(FN_BOUNDS, 0, 0, 0));
            endcase
        end
    endtask

    // A small pool of cells, many crowded into a few buckets, worked with mixed operations.
    task automatic run_pool();
        t_in         pool[$];
        int          size_sel;
        int unsigned r;
        t_in         picked;
        size_sel = $urandom_range(8, 40);
        for (int i = 0; i < size_sel; i++) begin
            if ($urandom_range(0, 1)) pool.push_back(cell_in_bucket($urandom_range(0, 3)));
            else pool.push_back(make_op(FN_ADD, rand_coord(), rand_coord(), rand_coord()));
        end
        for (int i = 0; i < 60; i++) begin
            r = $urandom_range(0, 99);
            picked = pool[$urandom_range(0, pool.size() - 1)];
            if (r < 40) send_as(FN_ADD, picked);
            else if (r < 58) send_as(FN_CONTAINS, picked);
            else if (r < 76) send_as(FN_REMOVE, picked);
            else if (r < 84) send_op(make_op(FN_BOUNDS, rand_coord(), rand_coord(), rand_coord()));
            else if (r < 86) send_op(make_op(FN_CLEAR, rand_coord(), rand_coord(), rand_coord()));
            else if (r < 89)
                send_op(make_op(FUNC_W'($urandom_range(FN_SPARE_HI, FN_SPARE_LO)),
                                rand_coord(), rand_coord(), rand_coord()));
            else if (r < 95)
                send_op(make_op(FN_CONTAINS, rand_coord(), rand_coord(), rand_coord()));
            else send_op(make_op(FN_REMOVE, rand_coord(), rand_coord(), rand_coord()));
        end
    endtask

    task automatic run_noise();
        for (int i = 0; i < 30; i++)
            send_op(make_op(FUNC_W'($urandom_range(0, FN_SPARE_HI)), coord_t'($urandom),
                            coord_t'($urandom), coord_t'($urandom)));
    endtask

    initial begin
        int kind;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        while (sent < ITEM_TARGET) begin
            kind = $urandom_range(0, 9);
            if (kind <= 1) run_packing();
            else if (kind <= 7) run_pool();
            else run_noise();
        end
        i_in_valid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d items and checked %0d results, %0d mismatching.",
                 sent, tracker.checked, tracker.mismatches);
        $display("Saw %0d full-bucket refusals, %0d bounds on an empty set, peak population %0d.",
                 tracker.refusals, tracker.empty_bounds, tracker.peak);
        if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/hcs_pkg.sv
design/hcs_ram.sv
design/hcs_ctrl.sv
design/hcs_dp.sv
design/hashed_cell_set_with_bounds_top.sv
tb/tb_top.sv
